>>> sv/sfcwd_pkg.sv
// ----------------------------------------------------------------------------
// sfcwd_pkg: shared constants and helpers for the CRC word deframer
// Frame geometry, CRC-8 constants, status codes and the CRC byte step.
// ----------------------------------------------------------------------------
package sfcwd_pkg;

    // Frame geometry
    localparam int unsigned WORDS_PER_FRAME = 10;
    localparam int unsigned GROUP_BYTES     = 6;
    localparam int unsigned POS_W           = 3;
    localparam int unsigned GRP_W           = 4;

    localparam logic [GRP_W-1:0] LAST_GROUP_NUM = GRP_W'(WORDS_PER_FRAME - 1);

    // CRC-8: polynomial 0x31, init 0xFF, no reflection, no final xor
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Byte positions within a group
    localparam logic [POS_W-1:0] POS_UPPER_HI = 3'd0;
    localparam logic [POS_W-1:0] POS_UPPER_LO = 3'd1;
    localparam logic [POS_W-1:0] POS_UPPER_CRC = 3'd2;
    localparam logic [POS_W-1:0] POS_LOWER_HI = 3'd3;
    localparam logic [POS_W-1:0] POS_LOWER_LO = 3'd4;
    localparam logic [POS_W-1:0] POS_LOWER_CRC = 3'd5;

    // Group status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UPPER_ERR = 2'd1,
        ST_LOWER_ERR = 2'd2
    } t_status;

    // One result item
    typedef struct packed {
        logic [GRP_W-1:0] group_number;
        logic [3:0]       slot_index;
        logic [31:0]      word_value;
    } t_result;

    // One CRC byte step, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> sv/sensor_frame_crc_word_deframer_core.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_word_deframer_core
// Checks six-byte groups (two data bytes + CRC-8, twice) and emits one word
// or error status per group, with compacted slot numbers for good words.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                        | tuser        | tlast
//  s_axis   | in  | data_byte[7:0]                            | frame_start  | -
//  m_axis   | out | word_value[31:0], slot_index[35:32],      | group_status | last_group
//           |     | group_number[39:36]                       |              |
//
//  One byte per cycle sustained while m_axis does not stall; each byte is held
//  in the input register, where the CRC/state step runs, and its result goes to
//  the output register as it leaves. Only the sixth byte of a group yields an item.
//  Reset (synchronous, active low) clears counters and sets the CRC to 0xFF.
//  A stall on m_axis with a result waiting holds the input register; s_axis
//  ready follows within the same cycle once the output register drains.
// ----------------------------------------------------------------------------
module sensor_frame_crc_word_deframer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte[7:0]
    input  logic        i_s_axis_tuser,   // frame_start
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // word_value[31:0], slot_index[35:32],
                                          // group_number[39:36]
    output logic [1:0]  o_m_axis_tuser,   // group_status[1:0]
    output logic        o_m_axis_tlast    // last_group
);

    // Input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    // Deframer state
    logic [sfcwd_pkg::POS_W-1:0] r_byte_pos, n_byte_pos;
    logic [sfcwd_pkg::GRP_W-1:0] r_group_cnt, n_group_cnt;
    logic [3:0]                  r_good_cnt, n_good_cnt;
    logic [7:0]                  r_crc, n_crc;
    logic [15:0]                 r_upper, n_upper;
    logic [15:0]                 r_lower, n_lower;
    logic                        r_upper_good, n_upper_good;

    // Output register
    logic                r_out_vld;
    sfcwd_pkg::t_result  r_out, n_out;
    sfcwd_pkg::t_status  r_out_status, n_out_status;
    logic                r_out_last, n_out_last;
    logic                n_emit;

    logic advance;
    logic in_take;

    // Process the held byte when the output register can take a result
    assign advance         = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || advance;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        logic [sfcwd_pkg::POS_W-1:0] pos;
        logic [sfcwd_pkg::GRP_W-1:0] grp;
        logic [3:0]                  good;
        logic [7:0]                  crc;
        logic                        last;
        pos  = r_in_start ? '0 : r_byte_pos;
        grp  = r_in_start ? '0 : r_group_cnt;
        good = r_in_start ? '0 : r_good_cnt;
        crc  = r_in_start ? sfcwd_pkg::CRC_INIT : r_crc;
        last = (grp >= sfcwd_pkg::LAST_GROUP_NUM);

        n_byte_pos   = pos + 3'd1;
        n_group_cnt  = grp;
        n_good_cnt   = good;
        n_crc        = sfcwd_pkg::crc8_step(crc, r_in_byte);
        n_upper      = r_upper;
        n_lower      = r_lower;
        n_upper_good = r_upper_good;
        n_emit       = 1'b0;
        n_out        = '0;
        n_out_status = sfcwd_pkg::ST_OK;
        n_out_last   = last;

        case (pos)
            sfcwd_pkg::POS_UPPER_HI:  n_upper = {r_in_byte, 8'h00};
            sfcwd_pkg::POS_UPPER_LO:  n_upper = {r_upper[15:8], r_in_byte};
            sfcwd_pkg::POS_UPPER_CRC: begin
                n_upper_good = (crc == r_in_byte);
                n_crc        = sfcwd_pkg::CRC_INIT;
            end
            sfcwd_pkg::POS_LOWER_HI:  n_lower = {r_in_byte, 8'h00};
            sfcwd_pkg::POS_LOWER_LO:  n_lower = {r_lower[15:8], r_in_byte};
            default: begin
                // sixth byte: check lower CRC and emit
                n_emit     = 1'b1;
                n_crc      = sfcwd_pkg::CRC_INIT;
                n_byte_pos = '0;
                if (!r_upper_good) begin
                    n_out_status = sfcwd_pkg::ST_UPPER_ERR;
                end else if (crc != r_in_byte) begin
                    n_out_status = sfcwd_pkg::ST_LOWER_ERR;
                end else begin
                    n_out_status     = sfcwd_pkg::ST_OK;
                    n_out.word_value = {r_upper, r_lower};
                    n_out.slot_index = good;
                    n_good_cnt       = good + 4'd1;
                end
                n_out.group_number = grp;
                if (last) begin
                    n_group_cnt = '0;
                    n_good_cnt  = '0;
                end else begin
                    n_group_cnt = grp + 4'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_byte_pos   <= '0;
            r_group_cnt  <= '0;
            r_good_cnt   <= '0;
            r_crc        <= sfcwd_pkg::CRC_INIT;
            r_upper_good <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end

            if (advance) begin
                r_byte_pos   <= n_byte_pos;
                r_group_cnt  <= n_group_cnt;
                r_good_cnt   <= n_good_cnt;
                r_crc        <= n_crc;
                r_upper_good <= n_upper_good;
            end

            if (advance && n_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte  <= i_s_axis_tdata;
            r_in_start <= i_s_axis_tuser;
        end
        if (advance) begin
            r_upper <= n_upper;
            r_lower <= n_lower;
        end
        if (advance && n_emit) begin
            r_out        <= n_out;
            r_out_status <= n_out_status;
            r_out_last   <= n_out_last;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_pos <= sfcwd_pkg::POS_LOWER_CRC)
        else $error("byte position out of group range");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != sfcwd_pkg::ST_OK)
            |-> (o_m_axis_tdata[35:0] == 36'd0))
        else $error("error item carries word or slot");

    a_last_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast)
            |-> (o_m_axis_tdata[39:36] == sfcwd_pkg::LAST_GROUP_NUM))
        else $error("last group flag on wrong group");

    a_slot_le_grp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == sfcwd_pkg::ST_OK)
            |-> (o_m_axis_tdata[35:32] <= o_m_axis_tdata[39:36]))
        else $error("slot index ahead of group number");

endmodule
